@@ src/fud_pkg.sv @@
// shared types, constants and the flash map for the firmware update deframer
package fud_pkg;

  localparam int MaxPayload = 255;
  localparam int StoreDepth = 256;
  localparam int StoreWords = StoreDepth / 4;
  localparam int WordIdxW   = $clog2(StoreWords);

  localparam logic [7:0]  HeadByte   = 8'hA5;
  localparam logic [7:0]  TailByte   = 8'hAA;
  localparam logic [7:0]  IdKernel   = 8'h01;
  localparam logic [7:0]  IdLength   = 8'h02;
  localparam logic [27:0] BaseReset  = 28'h800_8000;
  localparam int          NumSectors = 12;

  // sector boundaries, the last entry is the end of flash
  localparam logic [32:0] SectorBound [NumSectors+1] = '{
    33'h0_0800_0000, 33'h0_0800_4000, 33'h0_0800_8000, 33'h0_0800_C000,
    33'h0_0801_0000, 33'h0_0802_0000, 33'h0_0804_0000, 33'h0_0806_0000,
    33'h0_0808_0000, 33'h0_080A_0000, 33'h0_080C_0000, 33'h0_080E_0000,
    33'h0_080E_0000 + 33'h0_0002_0000
  };

  typedef enum logic [2:0] {
    K_WRITE = 3'd0,
    K_ERASE = 3'd1,
    K_EMPTY = 3'd2,
    K_FERR  = 3'd3,
    K_RANGE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_WAIT     = 2'd0,
    PH_UPDATING = 2'd1,
    PH_DONE     = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    POS_HUNT = 3'd0,
    POS_ID   = 3'd1,
    POS_LEN  = 3'd2,
    POS_PAY  = 3'd3,
    POS_TAIL = 3'd4
  } pos_e;

  // what the last accepted byte asks for
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_FERR = 2'd1,
    EV_LEN  = 2'd2,
    EV_KER  = 2'd3
  } ev_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_LEN_END,
    ST_LEN_SEC,
    ST_LEN_DEC,
    ST_EMIT1,
    ST_KRD,
    ST_KWR
  } state_e;

  typedef struct packed {
    logic  accept;
    logic  emit;
    kind_e kind;
    logic  len_end;
    logic  len_sec;
    logic  len_empty;
    logic  len_erase;
    logic  k_init;
    logic  k_write;
  } cmd_t;

  typedef struct packed {
    ev_e  ev;
    logic upd;
    logic len_short;
    logic size_zero;
    logic len_zero;
    logic k_over;
    logic sec_ok;
    logic k_last;
    logic out_free;
  } status_t;

  // {in map, sector number}
  function automatic logic [4:0] sector_of(logic [32:0] addr);
    logic [4:0] res;
    res = '0;
    for (int s = 0; s < NumSectors; s++) begin
      if (addr >= SectorBound[s] && addr < SectorBound[s+1]) begin
        res = {1'b1, 4'(s)};
      end
    end
    return res;
  endfunction

endpackage

@@ src/fud_ctrl.sv @@
// sequencing state machine of the firmware update deframer
module fud_ctrl import fud_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= K_FERR;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = K_WRITE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = ST_CLASS;
      end
      ST_CLASS: begin
        case (status_i.ev)
          EV_NONE: state_d = ST_IDLE;
          EV_FERR: begin
            kind_d  = K_FERR;
            state_d = ST_EMIT1;
          end
          EV_LEN: begin
            if (status_i.upd || status_i.len_short) begin
              kind_d  = K_FERR;
              state_d = ST_EMIT1;
            end else if (status_i.size_zero) begin
              kind_d  = K_EMPTY;
              state_d = ST_EMIT1;
            end else begin
              state_d = ST_LEN_END;
            end
          end
          EV_KER: begin
            if (!status_i.upd) begin
              kind_d  = K_FERR;
              state_d = ST_EMIT1;
            end else if (status_i.len_zero) begin
              kind_d  = K_EMPTY;
              state_d = ST_EMIT1;
            end else if (status_i.k_over) begin
              kind_d  = K_RANGE;
              state_d = ST_EMIT1;
            end else begin
              cmd_o.k_init = 1'b1;
              state_d      = ST_KRD;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_LEN_END: begin
        cmd_o.len_end = 1'b1;
        state_d       = ST_LEN_SEC;
      end
      ST_LEN_SEC: begin
        cmd_o.len_sec = 1'b1;
        state_d       = ST_LEN_DEC;
      end
      ST_LEN_DEC: begin
        kind_d  = status_i.sec_ok ? K_ERASE : K_RANGE;
        state_d = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.kind      = kind_q;
          // state changes of a length frame go with its answer
          cmd_o.len_empty = (kind_q == K_EMPTY) && (status_i.ev == EV_LEN);
          cmd_o.len_erase = (kind_q == K_ERASE);
          state_d         = ST_IDLE;
        end
      end
      ST_KRD: state_d = ST_KWR;
      ST_KWR: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = K_WRITE;
          cmd_o.k_write = 1'b1;
          state_d       = status_i.k_last ? ST_IDLE : ST_KRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ src/fud_dp.sv @@
// parser registers, payload buffer, update bookkeeping and output register
module fud_dp import fud_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [27:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output kind_e       out_kind_o,
  output logic [31:0] out_addr_o,
  output logic [31:0] out_data_o,
  output logic [2:0]  out_count_o,
  output logic [3:0]  out_fs_o,
  output logic [3:0]  out_sc_o,
  output logic        out_done_o,
  output logic        out_last_o
);

  logic [27:0] base_q;
  phase_e      phase_q;
  pos_e        pos_q;
  logic [7:0]  type_q, len_q, pidx_q;
  ev_e         ev_q;
  logic [31:0] size_q, rem_q, paddr_q;
  logic [32:0] end_q;
  logic [3:0]  fs_q, ls_q;
  logic        sec_ok_q;
  logic [7:0]  left_q;
  logic [WordIdxW-1:0] widx_q;
  logic        out_valid_q;

  logic [3:0][7:0] store_mem [StoreWords];
  logic [3:0][7:0] rdata_q;

  logic [7:0]  pidx_inc;
  logic [2:0]  wcnt;
  logic [31:0] rem_next;
  logic [31:0] wword;
  logic [4:0]  base_sec, end_sec;
  logic        ferr_done;

  assign pidx_inc = pidx_q + 8'd1;
  assign wcnt     = (left_q > 8'd4) ? 3'd4 : left_q[2:0];
  assign rem_next = (rem_q > {29'd0, wcnt}) ? rem_q - {29'd0, wcnt} : 32'd0;
  assign base_sec = sector_of({5'd0, base_q});
  assign end_sec  = sector_of(end_q);
  assign ferr_done = (phase_q == PH_DONE);

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      wword[8*b +: 8] = (3'(b) < wcnt) ? rdata_q[b] : 8'd0;
    end
  end

  always_comb begin
    status_o.ev        = ev_q;
    status_o.upd       = (phase_q == PH_UPDATING);
    status_o.len_short = (len_q < 8'd4);
    status_o.size_zero = (size_q == 32'd0);
    status_o.len_zero  = (len_q == 8'd0);
    status_o.k_over    = ({1'b0, paddr_q} + {25'd0, len_q}) > SectorBound[NumSectors];
    status_o.sec_ok    = sec_ok_q;
    status_o.k_last    = (left_q <= 8'd4);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BaseReset;
      phase_q     <= PH_WAIT;
      pos_q       <= POS_HUNT;
      type_q      <= '0;
      len_q       <= '0;
      pidx_q      <= '0;
      ev_q        <= EV_NONE;
      rem_q       <= '0;
      paddr_q     <= {4'd0, BaseReset};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_data_i;

      if (cmd_i.accept) begin
        case (pos_q)
          POS_ID: begin
            type_q <= rx_byte_i;
            pos_q  <= POS_LEN;
            ev_q   <= EV_NONE;
          end
          POS_LEN: begin
            len_q  <= rx_byte_i;
            pidx_q <= '0;
            if ({1'b0, rx_byte_i} > 9'(MaxPayload)) begin
              pos_q <= POS_HUNT;
              ev_q  <= EV_FERR;
            end else begin
              pos_q <= (rx_byte_i == 8'd0) ? POS_TAIL : POS_PAY;
              ev_q  <= EV_NONE;
            end
          end
          POS_PAY: begin
            pidx_q <= pidx_inc;
            ev_q   <= EV_NONE;
            if (pidx_inc >= len_q) pos_q <= POS_TAIL;
          end
          POS_TAIL: begin
            pos_q <= POS_HUNT;
            if (rx_byte_i != TailByte) ev_q <= EV_FERR;
            else if (type_q == IdLength) ev_q <= EV_LEN;
            else if (type_q == IdKernel) ev_q <= EV_KER;
            else ev_q <= EV_FERR;
          end
          default: begin
            pos_q <= (rx_byte_i == HeadByte) ? POS_ID : POS_HUNT;
            ev_q  <= EV_NONE;
          end
        endcase
      end

      if (cmd_i.len_empty) begin
        rem_q   <= '0;
        paddr_q <= {4'd0, base_q};
        phase_q <= PH_DONE;
      end
      if (cmd_i.len_erase) begin
        rem_q   <= size_q;
        paddr_q <= {4'd0, base_q};
        phase_q <= PH_UPDATING;
      end
      if (cmd_i.k_write) begin
        rem_q   <= rem_next;
        paddr_q <= paddr_q + {29'd0, wcnt};
        if (rem_next == 32'd0) phase_q <= PH_DONE;
      end

      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload buffer, byte lanes of 32-bit words
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && pos_q == POS_PAY) begin
      store_mem[pidx_q[7:2]][pidx_q[1:0]] <= rx_byte_i;
    end
    rdata_q <= store_mem[widx_q];
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    // first four payload bytes, big-endian image size
    if (cmd_i.accept && pos_q == POS_PAY && pidx_q < 8'd4) begin
      size_q <= {size_q[23:0], rx_byte_i};
    end
    if (cmd_i.len_end) end_q <= {5'd0, base_q} + {1'b0, size_q} - 33'd1;
    if (cmd_i.len_sec) begin
      fs_q     <= base_sec[3:0];
      ls_q     <= end_sec[3:0];
      sec_ok_q <= base_sec[4] && end_sec[4];
    end
    if (cmd_i.k_init) begin
      widx_q <= '0;
      left_q <= len_q;
    end
    if (cmd_i.k_write) begin
      widx_q <= widx_q + WordIdxW'(1);
      left_q <= left_q - {5'd0, wcnt};
    end
    if (cmd_i.emit) begin
      out_kind_o <= cmd_i.kind;
      case (cmd_i.kind)
        K_WRITE: begin
          out_addr_o  <= paddr_q;
          out_data_o  <= wword;
          out_count_o <= wcnt;
          out_fs_o    <= '0;
          out_sc_o    <= '0;
          out_done_o  <= (rem_next == 32'd0);
          out_last_o  <= (left_q <= 8'd4);
        end
        K_ERASE: begin
          out_addr_o  <= {4'd0, base_q};
          out_data_o  <= '0;
          out_count_o <= '0;
          out_fs_o    <= fs_q;
          out_sc_o    <= ls_q - fs_q + 4'd1;
          out_done_o  <= 1'b0;
          out_last_o  <= 1'b1;
        end
        default: begin
          out_addr_o  <= '0;
          out_data_o  <= '0;
          out_count_o <= '0;
          out_fs_o    <= '0;
          out_sc_o    <= '0;
          out_done_o  <= (cmd_i.kind == K_EMPTY) ? (ev_q == EV_LEN) : ferr_done;
          out_last_o  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/firmware_update_deframer_core.sv @@
// firmware update deframer: byte stream in, flash erase and program requests out
// a byte is taken and classified in the next cycle; no new byte is taken until
// it is classified. An error or empty answer follows the classification, an erase
// request the end address, sector and range decision states. Kernel writes alternate
// read and write states, set by the single read port of the payload buffer
// asynchronous active-low reset, no clearing pass; results wait in an output register
module firmware_update_deframer_core import fud_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // flash_address, data_word, byte_count, first_sector, sector_count,
  // update_done, zero fill
  output logic [79:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [27:0] cfg_data_i      // image_base_address
);

  cmd_t        cmd;
  status_t     status;
  kind_e       out_kind;
  logic [31:0] out_addr, out_data;
  logic [2:0]  out_count;
  logic [3:0]  out_fs, out_sc;
  logic        out_done;

  assign cfg_ready_o = 1'b1;

  fud_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fud_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .rx_byte_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_addr_o  (out_addr),
    .out_data_o  (out_data),
    .out_count_o (out_count),
    .out_fs_o    (out_fs),
    .out_sc_o    (out_sc),
    .out_done_o  (out_done),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_done, out_sc, out_fs, out_count, out_data, out_addr};
  assign m_axis_tuser = out_kind;

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a waiting result");

  // no new byte while results of the previous one are still being produced
  a_no_accept_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && cmd.emit))
    else $error("byte accepted during result generation");

  // a program write carries one to four bytes
  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == K_WRITE) |->
      (m_axis_tdata[66:64] != 3'd0 && m_axis_tdata[66:64] <= 3'd4))
    else $error("program write with bad byte count");

  // an erase request starts an update, never reports it done and is always last
  a_erase_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == K_ERASE) |-> (!m_axis_tdata[75] && m_axis_tlast))
    else $error("erase request flagged done or not last");

endmodule

@@ verif/flash_request_tracker_pkg.sv @@
// prediction and checking of flash requests produced from a received byte stream
`timescale 1ns / 100ps
package flash_request_tracker_pkg;
  import fud_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  cnt;
    logic [3:0]  first_sec;
    logic [3:0]  sec_cnt;
    logic        done;
    logic        last;
  } flash_req_t;

  class flash_request_tracker;
    logic [27:0] base;
    phase_e      phase;
    pos_e        pos;
    logic [7:0]  id_byte;
    logic [7:0]  frame_len;
    logic [7:0]  pay_idx;
    logic [7:0]  pay_buf [StoreDepth];
    logic [31:0] bytes_left;
    logic [31:0] write_addr;
    flash_req_t  pending_flash_reqs [$];
    int          errors;

    function new();
      base       = BaseReset;
      phase      = PH_WAIT;
      pos        = POS_HUNT;
      id_byte    = '0;
      frame_len  = '0;
      pay_idx    = '0;
      bytes_left = '0;
      write_addr = {4'h0, BaseReset};
      errors     = 0;
    endfunction

    function void set_base(logic [27:0] v);
      base = v;
    endfunction

    function void expect_req(kind_e k, logic [31:0] a, logic [31:0] d, logic [2:0] c,
                             logic [3:0] f, logic [3:0] n, logic dn, logic l);
      flash_req_t r;
      r.kind      = k;
      r.addr      = a;
      r.data      = d;
      r.cnt       = c;
      r.first_sec = f;
      r.sec_cnt   = n;
      r.done      = dn;
      r.last      = l;
      pending_flash_reqs.push_back(r);
    endfunction

    // single-result answers carry only the done flag of the current phase
    function void expect_answer(kind_e k);
      expect_req(k, '0, '0, '0, '0, '0, phase == PH_DONE, 1'b1);
    endfunction

    function int sector_at(logic [32:0] a);
      int s;
      s = -1;
      for (int i = 0; i < NumSectors; i++) begin
        if (a >= SectorBound[i] && a < SectorBound[i+1]) s = i;
      end
      return s;
    endfunction

    function void close_length();
      logic [31:0] size;
      logic [32:0] start;
      int          fs;
      int          ls;
      if (phase == PH_UPDATING || frame_len < 8'd4) begin
        expect_answer(K_FERR);
        return;
      end
      size = {pay_buf[0], pay_buf[1], pay_buf[2], pay_buf[3]};
      if (size == 32'd0) begin
        bytes_left = '0;
        write_addr = {4'h0, base};
        phase      = PH_DONE;
        expect_answer(K_EMPTY);
        return;
      end
      start = {5'h0, base};
      fs = sector_at(start);
      ls = sector_at(start + {1'b0, size} - 33'd1);
      if (fs < 0 || ls < 0) begin
        expect_answer(K_RANGE);
        return;
      end
      bytes_left = size;
      write_addr = start[31:0];
      phase      = PH_UPDATING;
      expect_req(K_ERASE, start[31:0], '0, '0, 4'(fs), 4'(ls - fs + 1), 1'b0, 1'b1);
    endfunction

    function void close_kernel();
      int          len;
      int          n;
      int          cnt;
      logic [31:0] word;
      len = frame_len;
      if (phase != PH_UPDATING) begin
        expect_answer(K_FERR);
        return;
      end
      if (len == 0) begin
        expect_answer(K_EMPTY);
        return;
      end
      if ({1'b0, write_addr} + 33'(len) > SectorBound[NumSectors]) begin
        expect_answer(K_RANGE);
        return;
      end
      n = 0;
      while (n < len) begin
        cnt  = (len - n > 4) ? 4 : len - n;
        word = '0;
        for (int b = 0; b < cnt; b++) word[8*b +: 8] = pay_buf[n + b];
        // remaining size saturates, the last write may overshoot it
        bytes_left = (bytes_left > 32'(cnt)) ? bytes_left - 32'(cnt) : 32'd0;
        if (bytes_left == 32'd0) phase = PH_DONE;
        expect_req(K_WRITE, write_addr, word, 3'(cnt), '0, '0, bytes_left == 32'd0,
                   n + cnt >= len);
        write_addr += 32'(cnt);
        n += cnt;
      end
    endfunction

    function void take_rx_byte(logic [7:0] b);
      case (pos)
        POS_ID: begin
          id_byte = b;
          pos     = POS_LEN;
        end
        POS_LEN: begin
          frame_len = b;
          pay_idx   = '0;
          if (int'(b) > MaxPayload) begin
            pos = POS_HUNT;
            expect_answer(K_FERR);
          end else begin
            pos = (b == 8'd0) ? POS_TAIL : POS_PAY;
          end
        end
        POS_PAY: begin
          pay_buf[pay_idx] = b;
          pay_idx++;
          if (pay_idx >= frame_len) pos = POS_TAIL;
        end
        POS_TAIL: begin
          pos = POS_HUNT;
          if (b != TailByte) expect_answer(K_FERR);
          else if (id_byte == IdLength) close_length();
          else if (id_byte == IdKernel) close_kernel();
          else expect_answer(K_FERR);
        end
        default: begin
          pos = (b == HeadByte) ? POS_ID : POS_HUNT;
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: %s expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_flash_req(logic [2:0] kind, logic [79:0] d, logic last);
      flash_req_t e;
      if (pending_flash_reqs.size() == 0) begin
        $display("%0t: request kind %0d data %h last %b expected none", $time, kind, d, last);
        errors++;
        return;
      end
      e = pending_flash_reqs.pop_front();
      check_field("kind", e.kind, kind);
      check_field("flash_address", e.addr, d[31:0]);
      check_field("data_word", e.data, d[63:32]);
      check_field("byte_count", e.cnt, d[66:64]);
      check_field("first_sector", e.first_sec, d[70:67]);
      check_field("sector_count", e.sec_cnt, d[74:71]);
      check_field("update_done", e.done, d[75]);
      check_field("zero_fill", 32'd0, d[79:76]);
      check_field("last", e.last, last);
    endfunction
  endclass

endpackage

@@ verif/tb.sv @@
// testbench for the firmware update deframer: directed and random frames against a predictor
`timescale 1ns / 100ps
module tb;
  import fud_pkg::*;
  import flash_request_tracker_pkg::*;

  localparam int          CycleLimit  = 400000;
  localparam int          PhaseBytes  = 36;
  localparam int          DrainCycles = 20;
  localparam logic [27:0] BaseLow     = 28'h800_0000;
  localparam logic [27:0] BaseHigh    = 28'h80F_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // flash_address, data_word, byte_count, first_sector, sector_count,
  // update_done, zero fill
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [27:0] cfg_data_i;

  flash_request_tracker tracker = new();

  logic tx_gaps;
  logic rx_stalls;
  int   bytes_sent;
  int   cycle_count;

  firmware_update_deframer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // results are checked before the byte of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_flash_req(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) tracker.take_rx_byte(s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) tracker.set_base(cfg_data_i);
    end
  end

  initial begin : rx_side
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && rx_stalls && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 15);
      m_axis_tready <= (hold == 0);
      if (hold > 0) hold--;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [7:0] pay [$],
                            input logic [7:0] tail);
    send_byte(HeadByte);
    send_byte(id);
    send_byte(8'(pay.size()));
    foreach (pay[i]) send_byte(pay[i]);
    send_byte(tail);
  endtask

  // frames follow the predicted update phase so that most of them get through
  task automatic send_random_frame(input logic big_ok);
    logic [7:0]  pay [$];
    logic [7:0]  id;
    logic [7:0]  tail;
    logic [31:0] size;
    logic [32:0] room;
    int          len;
    int          pick;
    pay  = {};
    tail = TailByte;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // noise, sometimes a stray head that breaks the next frame
      send_byte(pick < 2 ? HeadByte : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    room = SectorBound[NumSectors] - {5'h0, tracker.base};
    if (pick < 12) begin
      id = 8'($urandom_range(0, 255));
      repeat ($urandom_range(0, 6)) pay.push_back(8'($urandom_range(0, 255)));
    end else if (tracker.phase == PH_UPDATING ? pick < 82 : pick < 28) begin
      id = IdKernel;
      if ($urandom_range(0, 49) == 0) len = MaxPayload;
      else if ($urandom_range(0, 15) == 0) len = 0;
      else len = $urandom_range(1, 16);
      repeat (len) pay.push_back(8'($urandom_range(0, 255)));
    end else begin
      id = IdLength;
      case ($urandom_range(0, 9))
        0: size = '0;
        1: size = $urandom;
        // exact fit to the end of flash, and one byte past it
        2: size = (room <= 33'd64) ? room[31:0] : 32'($urandom_range(1, 48));
        3: size = (room <= 33'd64) ? room[31:0] + 32'd1 : 32'($urandom_range(1, 48));
        4: size = big_ok ? 32'($urandom_range(1, 32'h2_0000)) : 32'($urandom_range(1, 64));
        default: size = $urandom_range(1, 48);
      endcase
      pay = {size[31:24], size[23:16], size[15:8], size[7:0]};
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) void'(pay.pop_back());
        1: repeat ($urandom_range(1, 4)) pay.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
    end
    if ($urandom_range(0, 19) == 0) tail = 8'($urandom_range(0, 255));
    send_frame(id, pay, tail);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_flash_reqs.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0]  frame_pay [$];
    logic [27:0] new_base;
    int          phase_start;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    tx_gaps       = 1'b0;
    rx_stalls     = 1'b0;
    bytes_sent    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // skipped bytes, a kernel frame before any update, then a tiny image
    send_byte(8'h00);
    send_byte(8'hFF);
    frame_pay = {};
    send_frame(IdKernel, frame_pay, TailByte);
    frame_pay = {8'h00, 8'h00, 8'h00, 8'h08};
    send_frame(IdLength, frame_pay, TailByte);
    frame_pay = {8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_frame(IdKernel, frame_pay, TailByte);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: new_base = BaseLow;
          2: new_base = BaseHigh;
          4: new_base = '0;
          5: new_base = 28'($urandom);
          7: new_base = BaseReset;
          default: new_base = 28'($urandom_range(BaseLow, BaseHigh));
        endcase
        @(negedge clk_i);
        cfg_valid_i <= 1'b1;
        cfg_data_i  <= new_base;
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
        @(negedge clk_i);
        cfg_valid_i <= 1'b0;
      end
      // the last phase runs without gaps or stalls
      tx_gaps   = (ph < 7) && ($urandom_range(0, 3) != 0);
      rx_stalls = (ph < 7) && ($urandom_range(0, 3) != 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_random_frame(ph == 7);
    end

    settle();
    if (tracker.errors == 0 && tracker.pending_flash_reqs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
